FILE: hw/rtl/jtl_pkg.sv
// Shared types, codes and character tables for the JSON token lexer.
package jtl_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_STRING   = 3'd1,
    PH_LITERAL  = 3'd2,
    PH_INT      = 3'd3,
    PH_ZERO     = 3'd4,
    PH_INT_DOT  = 3'd5,
    PH_ZERO_DOT = 3'd6,
    PH_FRAC     = 3'd7
  } phase_t;

  typedef enum logic [3:0] {
    K_LBRACE   = 4'd0,
    K_RBRACE   = 4'd1,
    K_LBRACKET = 4'd2,
    K_RBRACKET = 4'd3,
    K_COMMA    = 4'd4,
    K_COLON    = 4'd5,
    K_STRING   = 4'd6,
    K_LITERAL  = 4'd7,
    K_INTEGER  = 4'd8,
    K_FLOAT    = 4'd9,
    K_INVALID  = 4'd10
  } kind_t;

  typedef enum logic [1:0] {
    W_TRUE  = 2'd0,
    W_FALSE = 2'd1,
    W_NULL  = 2'd2
  } word_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    kind_t      token_kind;
    logic [7:0] token_length;
    logic       last_of_run;
  } out_item_t;

  // up to two results caused by one input beat
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } grp_t;

  typedef struct packed {
    logic err;
    logic push;
  } fe_stat_t;

  function automatic logic [2:0] word_len(input logic [1:0] w);
    word_len = (w == W_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] word_char(input logic [1:0] w, input logic [2:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    case (w)
      W_TRUE: begin
        case (p)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      W_FALSE: begin
        case (p)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (p)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'h00;
        endcase
      end
    endcase
    word_char = ch;
  endfunction

endpackage

FILE: hw/rtl/jtl_front.sv
// Front end: scanner state machine that classifies each byte into result groups.
module jtl_front
  import jtl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t item,
  output grp_t     grp,
  output fe_stat_t stat
);

  typedef struct packed {
    logic       hit;
    logic       bad;
    kind_t      kind;
    phase_t     phase;
    logic [1:0] word;
    logic       set_len;
    logic       set_lit;
  } idle_t;

  function automatic idle_t lex_idle(input logic [7:0] c);
    idle_t r;
    r = '{hit: 1'b0, bad: 1'b0, kind: K_INVALID, phase: PH_IDLE,
          word: W_TRUE, set_len: 1'b0, set_lit: 1'b0};
    case (c)
      " ", 8'h09, 8'h0A, 8'h0D: r.hit = 1'b0;
      "{": begin r.hit = 1'b1; r.kind = K_LBRACE; end
      "}": begin r.hit = 1'b1; r.kind = K_RBRACE; end
      "[": begin r.hit = 1'b1; r.kind = K_LBRACKET; end
      "]": begin r.hit = 1'b1; r.kind = K_RBRACKET; end
      ",": begin r.hit = 1'b1; r.kind = K_COMMA; end
      ":": begin r.hit = 1'b1; r.kind = K_COLON; end
      8'h22: begin r.phase = PH_STRING; r.set_len = 1'b1; end
      "t": begin r.phase = PH_LITERAL; r.word = W_TRUE; r.set_lit = 1'b1; end
      "f": begin r.phase = PH_LITERAL; r.word = W_FALSE; r.set_lit = 1'b1; end
      "n": begin r.phase = PH_LITERAL; r.word = W_NULL; r.set_lit = 1'b1; end
      "0": begin r.phase = PH_ZERO; r.set_len = 1'b1; end
      default: begin
        if (c inside {["1":"9"]}) begin
          r.phase = PH_INT;
          r.set_len = 1'b1;
        end else begin
          r.hit = 1'b1;
          r.bad = 1'b1;
          r.kind = K_INVALID;
        end
      end
    endcase
    lex_idle = r;
  endfunction

  function automatic out_item_t mk(input kind_t k, input logic [7:0] n);
    mk = '{token_kind: k, token_length: n, last_of_run: 1'b0};
  endfunction

  phase_t     phase, phase_next;
  logic [1:0] word, word_next;
  logic [2:0] pos, pos_next;
  logic [7:0] len, len_next;
  logic       err, err_next;

  idle_t      idl;
  logic [7:0] c;
  logic       digit;
  logic [7:0] n_inc;
  logic [7:0] int_len;
  logic [2:0] wlen;
  logic [2:0] pos_inc;
  logic       run_idle;
  logic [1:0] n_out;
  out_item_t  res0, res1;

  assign c       = item.char_byte;
  assign digit   = c inside {["0":"9"]};
  assign n_inc   = (len == 8'hFF) ? 8'hFF : len + 8'd1;
  assign int_len = (len == 8'hFF) ? 8'hFF : len - 8'd1;
  assign wlen    = word_len(word);
  assign pos_inc = pos + 3'd1;

  always_comb begin
    idl        = lex_idle(c);
    phase_next = phase;
    word_next  = word;
    pos_next   = pos;
    len_next   = len;
    err_next   = err;
    run_idle   = 1'b0;
    n_out      = 2'd0;
    res0       = '0;
    res1       = '0;
    if (accept && !err) begin
      if (item.mode) begin
        phase_next = PH_IDLE;
        case (phase)
          PH_IDLE: n_out = 2'd0;
          PH_INT: begin n_out = 2'd1; res0 = mk(K_INTEGER, len); end
          PH_FRAC: begin n_out = 2'd1; res0 = mk(K_FLOAT, len); end
          PH_LITERAL: begin
            n_out = 2'd1; res0 = mk(K_INVALID, {5'd0, pos}); err_next = 1'b1;
          end
          PH_INT_DOT: begin
            n_out = 2'd2;
            res0 = mk(K_INTEGER, int_len);
            res1 = mk(K_INVALID, 8'd1);
            err_next = 1'b1;
          end
          default: begin
            n_out = 2'd1; res0 = mk(K_INVALID, len); err_next = 1'b1;
          end
        endcase
      end else begin
        case (phase)
          PH_IDLE: run_idle = 1'b1;
          PH_STRING: begin
            if (c == 8'h22) begin
              n_out = 2'd1; res0 = mk(K_STRING, n_inc); phase_next = PH_IDLE;
            end else if (c == 8'h0A) begin
              n_out = 2'd1; res0 = mk(K_INVALID, n_inc);
              err_next = 1'b1; phase_next = PH_IDLE;
            end else begin
              len_next = n_inc;
            end
          end
          PH_LITERAL: begin
            if (pos < wlen && c == word_char(word, pos)) begin
              pos_next = pos_inc;
              if (pos_inc >= wlen) begin
                n_out = 2'd1; res0 = mk(K_LITERAL, {5'd0, wlen}); phase_next = PH_IDLE;
              end
            end else begin
              n_out = 2'd1; res0 = mk(K_INVALID, {5'd0, pos} + 8'd1);
              err_next = 1'b1; phase_next = PH_IDLE;
            end
          end
          PH_INT: begin
            if (digit) begin
              len_next = n_inc;
            end else if (c == ".") begin
              phase_next = PH_INT_DOT; len_next = n_inc;
            end else begin
              n_out = 2'd1; res0 = mk(K_INTEGER, len); run_idle = 1'b1;
            end
          end
          PH_ZERO: begin
            if (digit) begin
              len_next = n_inc;
            end else if (c == ".") begin
              phase_next = PH_ZERO_DOT; len_next = n_inc;
            end else begin
              n_out = 2'd1; res0 = mk(K_INVALID, n_inc);
              err_next = 1'b1; phase_next = PH_IDLE;
            end
          end
          PH_INT_DOT: begin
            if (digit) begin
              phase_next = PH_FRAC; len_next = n_inc;
            end else begin
              n_out = 2'd2;
              res0 = mk(K_INTEGER, int_len);
              res1 = mk(K_INVALID, 8'd2);
              err_next = 1'b1; phase_next = PH_IDLE;
            end
          end
          PH_ZERO_DOT: begin
            if (digit) begin
              phase_next = PH_FRAC; len_next = n_inc;
            end else begin
              n_out = 2'd1; res0 = mk(K_INVALID, n_inc);
              err_next = 1'b1; phase_next = PH_IDLE;
            end
          end
          default: begin
            if (digit) begin
              len_next = n_inc;
            end else begin
              n_out = 2'd1; res0 = mk(K_FLOAT, len); run_idle = 1'b1;
            end
          end
        endcase
        // relex the closing byte from idle
        if (run_idle) begin
          phase_next = idl.phase;
          if (idl.set_len) len_next = 8'd1;
          if (idl.set_lit) begin
            word_next = idl.word;
            pos_next  = 3'd1;
          end
          if (idl.hit) begin
            if (n_out == 2'd0) begin
              res0  = mk(idl.kind, 8'd1);
              n_out = 2'd1;
            end else begin
              res1  = mk(idl.kind, 8'd1);
              n_out = 2'd2;
            end
            if (idl.bad) err_next = 1'b1;
          end
        end
      end
    end
    if (n_out == 2'd1) res0.last_of_run = 1'b1;
    if (n_out == 2'd2) res1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      word  <= W_TRUE;
      pos   <= 3'd0;
      len   <= 8'd0;
      err   <= 1'b0;
    end else begin
      phase <= phase_next;
      word  <= word_next;
      pos   <= pos_next;
      len   <= len_next;
      err   <= err_next;
    end
  end

  assign grp.two    = (n_out == 2'd2);
  assign grp.first  = res0;
  assign grp.second = res1;
  assign stat.err   = err;
  assign stat.push  = (n_out != 2'd0);

endmodule

FILE: hw/rtl/jtl_queue.sv
// Short queue of result groups between the scanner and the output stage.
module jtl_queue
  import jtl_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  grp_t                       wr_grp,
  input  logic                       pop,
  output grp_t                       rd_grp,
  output logic                       nonempty,
  output logic                       full,
  output logic [$clog2(Depth+1)-1:0] count
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  grp_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] cnt;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    wrap_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wrap_inc(wr_ptr);
      if (pop)  rd_ptr <= wrap_inc(rd_ptr);
      if (push && !pop)      cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  assign rd_grp   = slots[rd_ptr];
  assign nonempty = (cnt != '0);
  assign full     = (cnt == CntW'(Depth));
  assign count    = cnt;

endmodule

FILE: hw/rtl/jtl_back.sv
// Back end: splits result groups into single beats behind an output register.
module jtl_back
  import jtl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  grp_t      q_grp,
  input  logic      q_nonempty,
  output logic      q_pop,
  output logic      token_valid,
  input  logic      token_ready,
  output out_item_t token
);

  logic      tok_valid;
  out_item_t tok;
  logic      sec_pend;
  out_item_t sec;
  logic      can_load;

  assign can_load = !tok_valid || token_ready;
  assign q_pop    = can_load && !sec_pend && q_nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      sec_pend  <= 1'b0;
    end else if (can_load) begin
      if (sec_pend) begin
        tok_valid <= 1'b1;
        sec_pend  <= 1'b0;
      end else if (q_nonempty) begin
        tok_valid <= 1'b1;
        sec_pend  <= q_grp.two;
      end else begin
        tok_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (sec_pend) begin
        tok <= sec;
      end else if (q_nonempty) begin
        tok <= q_grp.first;
        sec <= q_grp.second;
      end
    end
  end

  assign token_valid = tok_valid;
  assign token       = tok;

endmodule

FILE: hw/rtl/json_token_lexer.sv
// Top level of the JSON token lexer: scanner, result queue and output stage.
//
// Input channel item_valid/item_ready/item takes one beat per text byte
// (mode 0) or an end-of-input flush (mode 1). Output channel
// token_valid/token_ready/token gives one beat per token: kind, length and
// last_of_run, set on the final result caused by an input beat.
// The scanner takes one input beat per cycle and writes the zero, one or two
// results it causes as one group into a queue of QueueDepth groups; item_ready
// is low only while that queue is full. The output stage sends one result per
// cycle while token_ready is high, popping a group with its first result; a
// second result waits in a register and blocks the next pop until it is sent.
// Throughput: one input beat per cycle while token_ready stays high and
// results average at most one per beat.
// Reset clears the scanner to idle, drops queued results and any error.
// A stalled receiver holds the output register; the queue absorbs up to
// QueueDepth groups before item_ready drops. After an invalid token the block
// keeps taking beats but gives no results until reset.
module json_token_lexer
  import jtl_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      token_valid,
  input  logic      token_ready,
  output out_item_t token
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic            accept;
  grp_t            fe_grp;
  fe_stat_t        fe_stat;
  logic            q_push;
  logic            q_pop;
  grp_t            q_grp;
  logic            q_nonempty;
  logic            q_full;
  logic [CntW-1:0] q_count;

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;
  assign q_push     = fe_stat.push;

  jtl_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .grp    (fe_grp),
    .stat   (fe_stat)
  );

  jtl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_grp   (fe_grp),
    .pop      (q_pop),
    .rd_grp   (q_grp),
    .nonempty (q_nonempty),
    .full     (q_full),
    .count    (q_count)
  );

  jtl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_grp       (q_grp),
    .q_nonempty  (q_nonempty),
    .q_pop       (q_pop),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token       (token)
  );

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    fe_stat.err |=> fe_stat.err)
    else $error("error flag cleared without reset");

  a_no_push_after_err: assert property (@(posedge clk) disable iff (rst)
    fe_stat.err |-> !q_push)
    else $error("result pushed after error");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_nonempty)
    else $error("pop from empty queue");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> (q_count == $past(q_count) + 1'b1))
    else $error("queue count did not advance on push");

endmodule
